@@ rtl/r0smap_pkg.sv @@
// Package for the RAID-0 read segment mapper.
// Holds widths, the disk count, register indexes, microcode types and the ROM.
// No dependencies.
package r0smap_pkg;

  localparam int DISKS   = 2;
  localparam int DISK_W  = 3;
  localparam int VOL_W   = 48;
  localparam int LEN_W   = 21;
  localparam int OFF_W   = 49;
  localparam int SHIFT_W = 5;
  localparam int IMG_W   = 32;
  localparam int INS_W   = 26;
  localparam int SSIZE_W = 27;
  localparam int ADD_W   = 33;
  localparam int STEP_W  = 2;

  localparam int DIG_W     = 4;
  localparam int DIGS_CYC  = 4;
  localparam int CHUNK_W   = DIG_W * DIGS_CYC;
  localparam int DIV_CYC   = VOL_W / CHUNK_W;
  localparam int DIVCNT_W  = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd26;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd22;
  localparam logic [IMG_W-1:0]   IMG_RESET   = 32'(4 << 20);
  localparam logic [LEN_W-1:0]   LEN_MAX     = 21'd1048576;

  localparam logic [0:0] REG_STRIPE_SHIFT = 1'b0;
  localparam logic [0:0] REG_IMAGE_OFFSET = 1'b1;

  typedef enum logic [1:0] {OP_ACCEPT, OP_DIV, OP_SETUP, OP_EMIT} op_t;
  typedef enum logic [1:0] {JC_NONE, JC_NO_BEAT, JC_DIV_MORE, JC_SEG_MORE} jc_t;

  typedef struct packed {
    op_t              op;
    jc_t              jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [DIG_W-1:0]  q;
    logic [DISK_W-1:0] r;
  } qdig_t;

  localparam logic [STEP_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STEP_W-1:0] ST_DIV    = 2'd1;
  localparam logic [STEP_W-1:0] ST_SETUP  = 2'd2;
  localparam logic [STEP_W-1:0] ST_EMIT   = 2'd3;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      ST_ACCEPT: w = '{op: OP_ACCEPT, jc: JC_NO_BEAT,  target: ST_ACCEPT};
      ST_DIV:    w = '{op: OP_DIV,    jc: JC_DIV_MORE, target: ST_DIV};
      ST_SETUP:  w = '{op: OP_SETUP,  jc: JC_NONE,     target: ST_EMIT};
      ST_EMIT:   w = '{op: OP_EMIT,   jc: JC_SEG_MORE, target: ST_EMIT};
      default:   w = '{op: OP_ACCEPT, jc: JC_NONE,     target: ST_ACCEPT};
    endcase
    return w;
  endfunction

  // one quotient digit of a division by DISKS, remainder carried in
  function automatic qdig_t div_digit(input logic [DISK_W-1:0] r,
                                      input logic [DIG_W-1:0] d);
    qdig_t res;
    int    v;
    v     = int'({r, d});
    res.q = DIG_W'(v / DISKS);
    res.r = DISK_W'(v % DISKS);
    return res;
  endfunction

endpackage

@@ rtl/raid0_read_segment_mapper_core.sv @@
// Top level of the RAID-0 read segment mapper: microcoded sequencer and datapath.
// Depends on r0smap_pkg.
//
// A read request (volume byte offset, length) is split into per-disk segments, one
// output beat each, the last flagged by out_last_segment. A request of N segments
// (1 to 33) passes one accept step, three steps that form stripe / DISKS four
// quotient digits at a time, one setup step, then the emit step, which sends one
// segment per cycle while the output is taken. The output register holds one
// beat, so the next request is accepted while the final segment still waits. The
// disk count is the package constant DISKS. Stripe shift is sampled on accept, the
// image offset in setup and emit; configuration writes belong in idle periods only.
module raid0_read_segment_mapper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [r0smap_pkg::VOL_W-1:0]        in_volume_offset,
  input  logic [r0smap_pkg::LEN_W-1:0]        in_request_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [r0smap_pkg::DISK_W-1:0]       out_disk_select,
  output logic [r0smap_pkg::OFF_W-1:0]        out_disk_byte_offset,
  output logic [r0smap_pkg::LEN_W-1:0]        out_segment_length,
  output logic [r0smap_pkg::LEN_W-1:0]        out_buffer_offset,
  output logic [r0smap_pkg::LEN_W-1:0]        out_bytes_total,
  output logic                                out_last_segment,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [r0smap_pkg::IMG_W-1:0]        cfg_data
);

  logic [r0smap_pkg::SHIFT_W-1:0]  cfg_shift_r;
  logic [r0smap_pkg::IMG_W-1:0]    cfg_img_r;

  logic [r0smap_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [r0smap_pkg::DIVCNT_W-1:0] divcnt_r, divcnt_nxt;
  logic [r0smap_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [r0smap_pkg::VOL_W-1:0]    stripe_r, stripe_nxt;
  logic [r0smap_pkg::VOL_W-1:0]    divq_r, divq_nxt;
  logic [r0smap_pkg::DISK_W-1:0]   rmd_r, rmd_nxt;
  logic [r0smap_pkg::INS_W-1:0]    ins_r, ins_nxt;
  logic [r0smap_pkg::LEN_W-1:0]    rem_r, rem_nxt;
  logic [r0smap_pkg::LEN_W-1:0]    done_r, done_nxt;
  logic [r0smap_pkg::DISK_W-1:0]   disk_r, disk_nxt;
  logic [r0smap_pkg::VOL_W-1:0]    rowb_r, rowb_nxt;
  logic [r0smap_pkg::ADD_W-1:0]    addend_r, addend_nxt;
  logic [r0smap_pkg::SSIZE_W-1:0]  room_r, room_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [r0smap_pkg::DISK_W-1:0]   o_disk_r, o_disk_nxt;
  logic [r0smap_pkg::OFF_W-1:0]    o_off_r, o_off_nxt;
  logic [r0smap_pkg::LEN_W-1:0]    o_seg_r, o_seg_nxt;
  logic [r0smap_pkg::LEN_W-1:0]    o_buf_r, o_buf_nxt;
  logic [r0smap_pkg::LEN_W-1:0]    o_tot_r, o_tot_nxt;
  logic                            o_last_r, o_last_nxt;

  r0smap_pkg::uword_t              uw;
  logic                            in_beat;
  logic                            emit_go;
  logic                            seg_last;
  logic                            jump;
  logic [r0smap_pkg::SHIFT_W-1:0]  eff_shift;
  logic [r0smap_pkg::SSIZE_W-1:0]  ssize;
  logic [r0smap_pkg::VOL_W-1:0]    smask;
  logic [r0smap_pkg::LEN_W-1:0]    seg;
  logic [r0smap_pkg::VOL_W-1:0]    stripe_inc;
  logic [r0smap_pkg::CHUNK_W-1:0]  chunk_q;
  logic [r0smap_pkg::DISK_W-1:0]   chunk_r;
  r0smap_pkg::qdig_t               dig;

  assign uw        = r0smap_pkg::ucode_rom(step_r);
  assign in_ready  = (uw.op == r0smap_pkg::OP_ACCEPT);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign emit_go   = (uw.op == r0smap_pkg::OP_EMIT) && (!out_valid_r || out_ready);
  assign ssize     = r0smap_pkg::SSIZE_W'(1) << shift_r;
  assign smask     = {r0smap_pkg::VOL_W{1'b1}} >> shift_r;
  assign seg       = ({6'd0, rem_r} > room_r) ? r0smap_pkg::LEN_W'(room_r) : rem_r;
  assign seg_last  = (rem_r == seg);
  assign stripe_inc = (stripe_r + r0smap_pkg::VOL_W'(1)) & smask;

  always_comb begin
    if (cfg_shift_r < r0smap_pkg::SHIFT_MIN) begin
      eff_shift = r0smap_pkg::SHIFT_MIN;
    end else if (cfg_shift_r > r0smap_pkg::SHIFT_MAX) begin
      eff_shift = r0smap_pkg::SHIFT_MAX;
    end else begin
      eff_shift = cfg_shift_r;
    end
  end

  // four dependent quotient digits of the top chunk
  always_comb begin
    chunk_r = rmd_r;
    chunk_q = '0;
    dig     = '0;
    for (int j = 0; j < r0smap_pkg::DIGS_CYC; j++) begin
      dig = r0smap_pkg::div_digit(chunk_r,
              divq_r[r0smap_pkg::VOL_W-1-j*r0smap_pkg::DIG_W -: r0smap_pkg::DIG_W]);
      chunk_q[r0smap_pkg::CHUNK_W-1-j*r0smap_pkg::DIG_W -: r0smap_pkg::DIG_W] = dig.q;
      chunk_r = dig.r;
    end
  end

  always_comb begin
    case (uw.jc)
      r0smap_pkg::JC_NO_BEAT:  jump = !in_beat;
      r0smap_pkg::JC_DIV_MORE: jump = (divcnt_r != r0smap_pkg::DIVCNT_W'(r0smap_pkg::DIV_CYC - 1));
      r0smap_pkg::JC_SEG_MORE: jump = !(emit_go && seg_last);
      default:                 jump = 1'b0;
    endcase
    step_nxt = jump ? uw.target : step_r + r0smap_pkg::STEP_W'(1);
  end

  always_comb begin
    divcnt_nxt    = divcnt_r;
    shift_nxt     = shift_r;
    stripe_nxt    = stripe_r;
    divq_nxt      = divq_r;
    rmd_nxt       = rmd_r;
    ins_nxt       = ins_r;
    rem_nxt       = rem_r;
    done_nxt      = done_r;
    disk_nxt      = disk_r;
    rowb_nxt      = rowb_r;
    addend_nxt    = addend_r;
    room_nxt      = room_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_disk_nxt    = o_disk_r;
    o_off_nxt     = o_off_r;
    o_seg_nxt     = o_seg_r;
    o_buf_nxt     = o_buf_r;
    o_tot_nxt     = o_tot_r;
    o_last_nxt    = o_last_r;
    case (uw.op)
      r0smap_pkg::OP_ACCEPT: begin
        if (in_beat) begin
          shift_nxt  = eff_shift;
          stripe_nxt = in_volume_offset >> eff_shift;
          divq_nxt   = in_volume_offset >> eff_shift;
          rmd_nxt    = '0;
          divcnt_nxt = '0;
          ins_nxt    = r0smap_pkg::INS_W'(in_volume_offset &
                         ((r0smap_pkg::VOL_W'(1) << eff_shift) - r0smap_pkg::VOL_W'(1)));
          rem_nxt    = (in_request_length > r0smap_pkg::LEN_MAX) ?
                         r0smap_pkg::LEN_MAX : in_request_length;
          done_nxt   = '0;
        end
      end
      r0smap_pkg::OP_DIV: begin
        divq_nxt   = {divq_r[r0smap_pkg::VOL_W-r0smap_pkg::CHUNK_W-1:0], chunk_q};
        rmd_nxt    = chunk_r;
        divcnt_nxt = divcnt_r + r0smap_pkg::DIVCNT_W'(1);
      end
      r0smap_pkg::OP_SETUP: begin
        disk_nxt   = rmd_r;
        rowb_nxt   = divq_r << shift_r;
        addend_nxt = r0smap_pkg::ADD_W'(cfg_img_r) + r0smap_pkg::ADD_W'(ins_r);
        room_nxt   = ssize - r0smap_pkg::SSIZE_W'(ins_r);
      end
      r0smap_pkg::OP_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          o_disk_nxt    = disk_r;
          o_off_nxt     = r0smap_pkg::OFF_W'(rowb_r) + r0smap_pkg::OFF_W'(addend_r);
          o_seg_nxt     = seg;
          o_buf_nxt     = done_r;
          o_tot_nxt     = done_r + seg;
          o_last_nxt    = seg_last;
          rem_nxt       = rem_r - seg;
          done_nxt      = done_r + seg;
          addend_nxt    = r0smap_pkg::ADD_W'(cfg_img_r);
          room_nxt      = ssize;
          stripe_nxt    = stripe_inc;
          // wrap at the volume end restarts at disk zero, row zero
          if (stripe_inc == '0) begin
            disk_nxt = '0;
            rowb_nxt = '0;
          end else if (disk_r == r0smap_pkg::DISK_W'(r0smap_pkg::DISKS - 1)) begin
            disk_nxt = '0;
            rowb_nxt = rowb_r + r0smap_pkg::VOL_W'(ssize);
          end else begin
            disk_nxt = disk_r + r0smap_pkg::DISK_W'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= r0smap_pkg::ST_ACCEPT;
      out_valid_r <= 1'b0;
      cfg_shift_r <= r0smap_pkg::SHIFT_RESET;
      cfg_img_r   <= r0smap_pkg::IMG_RESET;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          r0smap_pkg::REG_STRIPE_SHIFT: cfg_shift_r <= cfg_data[r0smap_pkg::SHIFT_W-1:0];
          r0smap_pkg::REG_IMAGE_OFFSET: cfg_img_r   <= cfg_data;
          default:                      cfg_img_r   <= cfg_img_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    divcnt_r <= divcnt_nxt;
    shift_r  <= shift_nxt;
    stripe_r <= stripe_nxt;
    divq_r   <= divq_nxt;
    rmd_r    <= rmd_nxt;
    ins_r    <= ins_nxt;
    rem_r    <= rem_nxt;
    done_r   <= done_nxt;
    disk_r   <= disk_nxt;
    rowb_r   <= rowb_nxt;
    addend_r <= addend_nxt;
    room_r   <= room_nxt;
    o_disk_r <= o_disk_nxt;
    o_off_r  <= o_off_nxt;
    o_seg_r  <= o_seg_nxt;
    o_buf_r  <= o_buf_nxt;
    o_tot_r  <= o_tot_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_disk_select      = o_disk_r;
  assign out_disk_byte_offset = o_off_r;
  assign out_segment_length   = o_seg_r;
  assign out_buffer_offset    = o_buf_r;
  assign out_bytes_total      = o_tot_r;
  assign out_last_segment     = o_last_r;

`ifndef ASSERT_OFF
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && seg_last) |=> (rem_r == '0))
    else $error("last segment left bytes owed");

  a_disk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == r0smap_pkg::OP_EMIT) |-> (disk_r < r0smap_pkg::DISK_W'(r0smap_pkg::DISKS)))
    else $error("disk index out of range");

  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_tot_r == o_buf_r + o_seg_r))
    else $error("bytes total does not match buffer offset plus length");

  a_seg_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_seg_r <= r0smap_pkg::LEN_MAX))
    else $error("segment longer than the request limit");
`endif

endmodule

@@ sim/raid0_read_segment_mapper_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for raid0_read_segment_mapper_core: predicts the per-disk segments
// of each accepted read and checks every output beat in order. Depends on r0smap_pkg.

class segment_tracker;
  typedef struct packed {
    logic [r0smap_pkg::DISK_W-1:0] disk;
    logic [r0smap_pkg::OFF_W-1:0]  offset;
    logic [r0smap_pkg::LEN_W-1:0]  length;
    logic [r0smap_pkg::LEN_W-1:0]  buf_offset;
    logic [r0smap_pkg::LEN_W-1:0]  total;
    logic                          last;
  } segment_t;

  logic [r0smap_pkg::SHIFT_W-1:0] stripe_shift = r0smap_pkg::SHIFT_RESET;
  logic [r0smap_pkg::IMG_W-1:0]   img_base     = r0smap_pkg::IMG_RESET;
  segment_t                       pending_segments[$];
  int unsigned                    errors = 0;

  function int unsigned eff_shift();
    if (stripe_shift < r0smap_pkg::SHIFT_MIN) return r0smap_pkg::SHIFT_MIN;
    if (stripe_shift > r0smap_pkg::SHIFT_MAX) return r0smap_pkg::SHIFT_MAX;
    return stripe_shift;
  endfunction

  function int unsigned pending();
    return pending_segments.size();
  endfunction

  task report(string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function void map_request(logic [r0smap_pkg::VOL_W-1:0] voff,
                            logic [r0smap_pkg::LEN_W-1:0] len);
    int unsigned                  sh;
    logic [63:0]                  ssize, in_stripe, stripe, row, room, wrap_mask, sum;
    logic [r0smap_pkg::LEN_W-1:0] rem, done;
    segment_t                     s;
    sh        = eff_shift();
    ssize     = 64'd1 << sh;
    in_stripe = 64'(voff) & (ssize - 64'd1);
    stripe    = 64'(voff) >> sh;
    wrap_mask = (64'd1 << (r0smap_pkg::VOL_W - sh)) - 64'd1;
    rem       = (len > r0smap_pkg::LEN_MAX) ? r0smap_pkg::LEN_MAX : len;
    done      = '0;
    do begin
      room         = ssize - in_stripe;
      s.length     = (room < 64'(rem)) ? room[r0smap_pkg::LEN_W-1:0] : rem;
      s.disk       = 3'(stripe % 64'(r0smap_pkg::DISKS));
      row          = stripe / 64'(r0smap_pkg::DISKS);
      sum          = (row << sh) + in_stripe + 64'(img_base);
      s.offset     = sum[r0smap_pkg::OFF_W-1:0];
      s.buf_offset = done;
      rem          = rem - s.length;
      done         = done + s.length;
      s.total      = done;
      s.last       = (rem == '0);
      pending_segments.push_back(s);
      stripe       = (stripe + 64'd1) & wrap_mask;
      in_stripe    = '0;
    end while (rem != '0);
  endfunction

  task check_segment(logic [r0smap_pkg::DISK_W-1:0] disk,
                     logic [r0smap_pkg::OFF_W-1:0]  offset,
                     logic [r0smap_pkg::LEN_W-1:0]  length,
                     logic [r0smap_pkg::LEN_W-1:0]  buf_offset,
                     logic [r0smap_pkg::LEN_W-1:0]  total,
                     logic                          last);
    segment_t exp_s;
    if (pending_segments.size() == 0) begin
      report($sformatf("segment with nothing pending: disk %0d offset 0x%0h len %0d",
                       disk, offset, length));
      return;
    end
    exp_s = pending_segments.pop_front();
    if (disk !== exp_s.disk)
      report($sformatf("disk_select %0d, want %0d", disk, exp_s.disk));
    if (offset !== exp_s.offset)
      report($sformatf("disk_byte_offset 0x%0h, want 0x%0h", offset, exp_s.offset));
    if (length !== exp_s.length)
      report($sformatf("segment_length %0d, want %0d", length, exp_s.length));
    if (buf_offset !== exp_s.buf_offset)
      report($sformatf("buffer_offset %0d, want %0d", buf_offset, exp_s.buf_offset));
    if (total !== exp_s.total)
      report($sformatf("bytes_total %0d, want %0d", total, exp_s.total));
    if (last !== exp_s.last)
      report($sformatf("last_segment %0b, want %0b", last, exp_s.last));
  endtask
endclass

module raid0_read_segment_mapper_core_tb;

  localparam int RANDOM_PER_PHASE = 54;
  localparam int PHASES           = 7;
  localparam int DRAIN_CYCLES     = 12;

  logic                              clk;
  logic                              rst_n             = 1'b0;
  logic                              in_valid          = 1'b0;
  logic                              in_ready;
  logic [r0smap_pkg::VOL_W-1:0]      in_volume_offset  = '0;
  logic [r0smap_pkg::LEN_W-1:0]      in_request_length = '0;
  logic                              out_valid;
  logic                              out_ready         = 1'b0;
  logic [r0smap_pkg::DISK_W-1:0]     out_disk_select;
  logic [r0smap_pkg::OFF_W-1:0]      out_disk_byte_offset;
  logic [r0smap_pkg::LEN_W-1:0]      out_segment_length;
  logic [r0smap_pkg::LEN_W-1:0]      out_buffer_offset;
  logic [r0smap_pkg::LEN_W-1:0]      out_bytes_total;
  logic                              out_last_segment;
  logic                              cfg_valid         = 1'b0;
  logic                              cfg_ready;
  logic [0:0]                        cfg_index         = r0smap_pkg::REG_STRIPE_SHIFT;
  logic [r0smap_pkg::IMG_W-1:0]      cfg_data          = '0;

  segment_tracker tracker;
  bit             valid_up   = 1'b0;
  int unsigned    burst_left = 0;
  int unsigned    rx_cycle   = 0;

  raid0_read_segment_mapper_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_volume_offset     (in_volume_offset),
    .in_request_length    (in_request_length),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_disk_select      (out_disk_select),
    .out_disk_byte_offset (out_disk_byte_offset),
    .out_segment_length   (out_segment_length),
    .out_buffer_offset    (out_buffer_offset),
    .out_bytes_total      (out_bytes_total),
    .out_last_segment     (out_last_segment),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= (rx_cycle[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_segment(out_disk_select, out_disk_byte_offset, out_segment_length,
                            out_buffer_offset, out_bytes_total, out_last_segment);
  end

  task automatic send(logic [r0smap_pkg::VOL_W-1:0] voff,
                      logic [r0smap_pkg::LEN_W-1:0] len);
    int unsigned gap;
    if (!valid_up) in_valid <= 1'b1;
    valid_up = 1'b1;
    in_volume_offset  <= voff;
    in_request_length <= len;
    do @(posedge clk); while (!in_ready);
    tracker.map_request(voff, len);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every segment is back, then let the datapath go quiet
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [r0smap_pkg::IMG_W-1:0] shift_word,
                            logic [r0smap_pkg::IMG_W-1:0] image_word);
    cfg_valid <= 1'b1;
    cfg_index <= r0smap_pkg::REG_STRIPE_SHIFT;
    cfg_data  <= shift_word;
    do @(posedge clk); while (!cfg_ready);
    tracker.stripe_shift = shift_word[r0smap_pkg::SHIFT_W-1:0];
    cfg_index <= r0smap_pkg::REG_IMAGE_OFFSET;
    cfg_data  <= image_word;
    do @(posedge clk); while (!cfg_ready);
    tracker.img_base = image_word;
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_set();
    logic [63:0] ssize;
    ssize = 64'd1 << tracker.eff_shift();
    send(48'd0, 21'd0);
    send(48'd0, r0smap_pkg::LEN_MAX);
    send(48'hFFFF_FFFF_FFFF, r0smap_pkg::LEN_MAX);
    send(48'hFFFF_FFFF_FFFF, 21'd0);
    send(48'(ssize - 64'd1), 21'd2);
    send(48'(ssize * 64'd3), 21'h1F_FFFF);
    send(48'(ssize * 64'd5 - 64'd17), 21'(r0smap_pkg::LEN_MAX + 1));
    send(48'h5555_5555_5555, 21'h0A_AAAA);
  endtask

  task automatic random_request();
    int unsigned                  pick;
    logic [63:0]                  ssize, base;
    logic [r0smap_pkg::VOL_W-1:0] voff;
    logic [r0smap_pkg::LEN_W-1:0] len;
    ssize = 64'd1 << tracker.eff_shift();
    base  = {$urandom, $urandom};
    pick  = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: voff = base[r0smap_pkg::VOL_W-1:0];
      3, 4, 5: voff = 48'((base & ~(ssize - 64'd1)) - 64'($urandom_range(1, 8192)));
      6, 7:    voff = 48'(base & ~(ssize - 64'd1));
      8:       voff = 48'hFFFF_FFFF_FFFF -
                      48'($urandom_range(0, 3 * r0smap_pkg::LEN_MAX));
      default: voff = 48'($urandom_range(0, 32'(ssize * 64'd4)));
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0)       len = '0;
    else if (pick < 8)   len = 21'($urandom_range(1, 4096));
    else if (pick < 16)  len = 21'($urandom_range(1, r0smap_pkg::LEN_MAX));
    else if (pick < 18)  len = r0smap_pkg::LEN_MAX;
    else                 len = 21'($urandom_range(r0smap_pkg::LEN_MAX, 21'h1F_FFFF));
    send(voff, len);
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: write_regs(32'd15, 32'd0);
        2: write_regs(32'd26, 32'hFFFF_FFFF);
        3: write_regs(32'd3, $urandom);
        4: write_regs(32'd31, $urandom);
        5: write_regs(32'($urandom_range(15, 26)), $urandom);
        default: write_regs(32'hFFFF_FFF0, $urandom);
      endcase
      if (phase < 3) directed_set();
      repeat (RANDOM_PER_PHASE) random_request();
      settle();
    end
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/r0smap_pkg.sv
rtl/raid0_read_segment_mapper_core.sv
sim/raid0_read_segment_mapper_core_tb.sv
